### design/dvast_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual valve actuator self-test package
// Shared types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dvast_pkg;

    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int TIMER_BITS_DEF = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_CLOSE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_BACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_CHECK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CHECK  = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] DETECT_DELAY_RST = 24'd300000;
    localparam logic [CFG_W-1:0] DELAY_CLOSE_RST  = 24'd14400000;
    localparam logic [CFG_W-1:0] TURN_BACK_RST    = 24'd3000;
    localparam logic [CFG_W-1:0] LEFT_CHECK_RST   = 24'd9000;
    localparam logic [CFG_W-1:0] RIGHT_CHECK_RST  = 24'd10000;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_OPEN        = 3'd1,
        CMD_CLOSE       = 3'd2,
        CMD_LOCK        = 3'd3,
        CMD_UNLOCK      = 3'd4,
        CMD_DRY_CONTACT = 3'd5,
        CMD_DELAY_ARM   = 3'd6,
        CMD_DRIVE       = 3'd7
    } command_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RPT_NONE   = 2'd0,
        RPT_CLOSED = 2'd1,
        RPT_OPENED = 2'd2
    } report_t;

    typedef struct packed {
        logic       left_drive;
        logic       right_drive;
        logic       valve_is_open;
        logic       locked;
        logic       valve_usable;
        logic       left_fault;
        logic       right_fault;
        logic       left_testing;
        logic       right_testing;
        status_t    command_status;
        report_t    master_report;
        logic [1:0] check_report;
    } result_t;

endpackage
`default_nettype wire

### design/dvast_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual valve actuator self-test channels
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface dvast_req_if;
    logic                valid;
    logic                ready;
    dvast_pkg::command_t command;
    logic                level;
    logic                side;
    logic                left_open_switch;
    logic                right_open_switch;
    logic                mode_allows;

    modport source (
        output valid, command, level, side, left_open_switch, right_open_switch,
               mode_allows,
        input  ready
    );
    modport sink (
        input  valid, command, level, side, left_open_switch, right_open_switch,
               mode_allows,
        output ready
    );
endinterface

interface dvast_res_if;
    logic                 valid;
    logic                 ready;
    logic                 left_drive;
    logic                 right_drive;
    logic                 valve_is_open;
    logic                 locked;
    logic                 valve_usable;
    logic                 left_fault;
    logic                 right_fault;
    logic                 left_testing;
    logic                 right_testing;
    dvast_pkg::status_t   command_status;
    dvast_pkg::report_t   master_report;
    logic [1:0]           check_report;

    modport source (
        output valid, left_drive, right_drive, valve_is_open, locked, valve_usable,
               left_fault, right_fault, left_testing, right_testing,
               command_status, master_report, check_report,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, valve_is_open, locked, valve_usable,
               left_fault, right_fault, left_testing, right_testing,
               command_status, master_report, check_report,
        output ready
    );
endinterface

interface dvast_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dvast_pkg::CFG_IDX_W-1:0]   index;
    logic [dvast_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/dual_valve_actuator_self_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual valve actuator self-test
// Two-motor valve control with lock, delay-close and per-side self-test.
// ----------------------------------------------------------------------------
// Every request transaction (a command or a millisecond tick) produces one
// result transaction. A request is taken in any cycle in which the result
// register is empty or being drained, so the block sustains one transaction
// per clock; the result is registered and shows in the cycle after acceptance.
// All six countdown timers are advanced and fired in that single pass, in the
// fixed order detect, delay-close, left/right turn-back, left/right check.
// Configuration writes are accepted at any time and take effect on the next
// timer start; a period of zero counts as one tick.
module dual_valve_actuator_self_test #(
    parameter int TIMER_BITS = dvast_pkg::TIMER_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    dvast_cfg_if.sink   cfg,
    dvast_req_if.sink   request,
    dvast_res_if.source result
);

    localparam int CW = dvast_pkg::CFG_W;
    localparam int XW = (TIMER_BITS > CW) ? TIMER_BITS : CW;
    localparam logic [XW-1:0] TMAX_X = XW'({TIMER_BITS{1'b1}});
    localparam logic [TIMER_BITS-1:0] T_ZERO = '0;
    localparam logic [TIMER_BITS-1:0] T_ONE  = TIMER_BITS'(1);

    typedef logic [TIMER_BITS-1:0] timer_t;

    // Clamp a period to the timer range, zero counts as one
    function automatic timer_t load_value(input logic [CW-1:0] p);
        logic [XW-1:0] px;
        timer_t        v;
        px = XW'(p);
        if (px > TMAX_X) px = TMAX_X;
        v = TIMER_BITS'(px);
        if (v == T_ZERO) v = T_ONE;
        return v;
    endfunction

    function automatic timer_t count_down(input timer_t t);
        return (t != T_ZERO) ? t - T_ONE : t;
    endfunction

    // Configuration registers
    logic [CW-1:0] detect_cfg_reg, delay_cfg_reg, turn_back_cfg_reg;
    logic [CW-1:0] left_check_cfg_reg, right_check_cfg_reg;

    // Block state
    logic       open_reg, open_next;
    logic       lock_reg, lock_next;
    logic       usable_reg, usable_next;
    logic [1:0] fault_reg, fault_next;
    logic [1:0] testing_reg, testing_next;
    logic [1:0] drive_reg, drive_next;
    timer_t     detect_reg, detect_next;
    timer_t     delay_reg, delay_next;
    timer_t     turn_back_reg [2];
    timer_t     turn_back_next [2];
    timer_t     check_reg [2];
    timer_t     check_next [2];

    // Result register
    dvast_pkg::result_t res_reg, res_next;
    logic               res_valid_reg;

    // Work signals
    timer_t     per_detect, per_delay, per_turn_back;
    timer_t     per_check [2];
    logic [1:0] sw;
    logic       req_accept;
    logic       do_open, do_close;
    logic       pend_detect, pend_delay;
    logic [1:0] pend_turn_back, pend_check;
    dvast_pkg::status_t status;
    dvast_pkg::report_t master;
    logic [1:0] check_rpt;

    assign cfg.ready     = 1'b1;
    assign request.ready = !res_valid_reg || result.ready;
    assign req_accept    = request.valid && request.ready;

    assign per_detect    = load_value(detect_cfg_reg);
    assign per_delay     = load_value(delay_cfg_reg);
    assign per_turn_back = load_value(turn_back_cfg_reg);
    assign per_check[0]  = load_value(left_check_cfg_reg);
    assign per_check[1]  = load_value(right_check_cfg_reg);
    assign sw            = {request.right_open_switch, request.left_open_switch};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_cfg_reg      <= dvast_pkg::DETECT_DELAY_RST;
            delay_cfg_reg       <= dvast_pkg::DELAY_CLOSE_RST;
            turn_back_cfg_reg   <= dvast_pkg::TURN_BACK_RST;
            left_check_cfg_reg  <= dvast_pkg::LEFT_CHECK_RST;
            right_check_cfg_reg <= dvast_pkg::RIGHT_CHECK_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dvast_pkg::REG_DETECT_DELAY: detect_cfg_reg      <= cfg.data;
                dvast_pkg::REG_DELAY_CLOSE:  delay_cfg_reg       <= cfg.data;
                dvast_pkg::REG_TURN_BACK:    turn_back_cfg_reg   <= cfg.data;
                dvast_pkg::REG_LEFT_CHECK:   left_check_cfg_reg  <= cfg.data;
                dvast_pkg::REG_RIGHT_CHECK:  right_check_cfg_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        open_next         = open_reg;
        lock_next         = lock_reg;
        usable_next       = usable_reg;
        fault_next        = fault_reg;
        testing_next      = testing_reg;
        drive_next        = drive_reg;
        detect_next       = detect_reg;
        delay_next        = delay_reg;
        turn_back_next[0] = turn_back_reg[0];
        turn_back_next[1] = turn_back_reg[1];
        check_next[0]     = check_reg[0];
        check_next[1]     = check_reg[1];
        status            = dvast_pkg::ST_DONE;
        master            = dvast_pkg::RPT_NONE;
        check_rpt         = 2'b00;
        pend_detect       = 1'b0;
        pend_delay        = 1'b0;
        pend_turn_back    = 2'b00;
        pend_check        = 2'b00;

        do_open  = (request.command == dvast_pkg::CMD_OPEN) ||
                   (request.command == dvast_pkg::CMD_DRY_CONTACT &&
                    request.mode_allows && !request.level);
        do_close = (request.command == dvast_pkg::CMD_CLOSE) ||
                   (request.command == dvast_pkg::CMD_DRY_CONTACT &&
                    request.mode_allows && request.level);

        case (request.command)
            dvast_pkg::CMD_TICK:
            begin
                // Count all timers, then fire the expired ones in order
                pend_detect       = (detect_reg == T_ONE);
                pend_delay        = (delay_reg == T_ONE);
                detect_next       = count_down(detect_reg);
                delay_next        = count_down(delay_reg);
                for (int s = 0; s < 2; s++)
                begin
                    pend_turn_back[s] = (turn_back_reg[s] == T_ONE);
                    pend_check[s]     = (check_reg[s] == T_ONE);
                    turn_back_next[s] = count_down(turn_back_reg[s]);
                    check_next[s]     = count_down(check_reg[s]);
                end

                if (pend_detect && open_reg)
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        if (!sw[s])
                        begin
                            check_next[s]     = T_ZERO;
                            pend_check[s]     = 1'b0;
                            fault_next[s]     = 1'b0;
                            testing_next[s]   = 1'b1;
                            drive_next[s]     = 1'b0;
                            turn_back_next[s] = per_turn_back;
                            pend_turn_back[s] = 1'b0;
                        end
                    end
                end

                if (pend_delay && request.mode_allows)
                begin
                    lock_next  = 1'b1;
                    open_next  = 1'b0;
                    drive_next = 2'b00;
                    master     = dvast_pkg::RPT_CLOSED;
                    // Refused close keeps the timers running
                    if (usable_next)
                    begin
                        detect_next       = T_ZERO;
                        delay_next        = T_ZERO;
                        turn_back_next[0] = T_ZERO;
                        turn_back_next[1] = T_ZERO;
                        check_next[0]     = T_ZERO;
                        check_next[1]     = T_ZERO;
                        pend_turn_back    = 2'b00;
                        pend_check        = 2'b00;
                    end
                end

                for (int s = 0; s < 2; s++)
                begin
                    if (pend_turn_back[s])
                    begin
                        if (sw[s])
                        begin
                            drive_next[s] = 1'b1;
                            check_next[s] = per_check[s];
                            pend_check[s] = 1'b0;
                        end
                        else
                        begin
                            usable_next     = 1'b0;
                            fault_next[s]   = 1'b1;
                            testing_next[s] = 1'b0;
                        end
                    end
                end

                for (int s = 0; s < 2; s++)
                begin
                    if (pend_check[s])
                    begin
                        testing_next[s] = 1'b0;
                        if (!sw[s])
                        begin
                            if (!fault_next[1-s]) usable_next = 1'b1;
                            fault_next[s] = 1'b0;
                            check_rpt[s]  = 1'b1;
                        end
                        else
                        begin
                            usable_next   = 1'b0;
                            fault_next[s] = 1'b1;
                        end
                    end
                end
            end
            dvast_pkg::CMD_OPEN, dvast_pkg::CMD_CLOSE: ;
            dvast_pkg::CMD_LOCK:   lock_next = 1'b1;
            dvast_pkg::CMD_UNLOCK: lock_next = 1'b0;
            dvast_pkg::CMD_DRY_CONTACT:
            begin
                if (!request.mode_allows) status = dvast_pkg::ST_IGNORED;
            end
            dvast_pkg::CMD_DELAY_ARM:
            begin
                delay_next = request.level ? per_delay : T_ZERO;
            end
            dvast_pkg::CMD_DRIVE:
            begin
                drive_next[request.side] = request.level;
            end
            default: ;
        endcase

        if (do_open)
        begin
            if (lock_reg || !usable_reg)
            begin
                status = dvast_pkg::ST_REFUSED;
            end
            else
            begin
                open_next         = 1'b1;
                drive_next        = 2'b11;
                turn_back_next[0] = T_ZERO;
                turn_back_next[1] = T_ZERO;
                check_next[0]     = T_ZERO;
                check_next[1]     = T_ZERO;
                delay_next        = T_ZERO;
                detect_next       = per_detect;
                if (request.command == dvast_pkg::CMD_DRY_CONTACT)
                    master = dvast_pkg::RPT_OPENED;
            end
        end

        if (do_close)
        begin
            open_next  = 1'b0;
            drive_next = 2'b00;
            if (!usable_reg)
            begin
                status = dvast_pkg::ST_REFUSED;
            end
            else
            begin
                turn_back_next[0] = T_ZERO;
                turn_back_next[1] = T_ZERO;
                check_next[0]     = T_ZERO;
                check_next[1]     = T_ZERO;
                delay_next        = T_ZERO;
                detect_next       = T_ZERO;
                if (request.command == dvast_pkg::CMD_DRY_CONTACT)
                    master = dvast_pkg::RPT_CLOSED;
            end
        end

        res_next.left_drive     = drive_next[0];
        res_next.right_drive    = drive_next[1];
        res_next.valve_is_open  = open_next;
        res_next.locked         = lock_next;
        res_next.valve_usable   = usable_next;
        res_next.left_fault     = fault_next[0];
        res_next.right_fault    = fault_next[1];
        res_next.left_testing   = testing_next[0];
        res_next.right_testing  = testing_next[1];
        res_next.command_status = status;
        res_next.master_report  = master;
        res_next.check_report   = check_rpt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg         <= 1'b0;
            lock_reg         <= 1'b0;
            usable_reg       <= 1'b1;
            fault_reg        <= 2'b00;
            testing_reg      <= 2'b00;
            drive_reg        <= 2'b00;
            detect_reg       <= T_ZERO;
            delay_reg        <= T_ZERO;
            turn_back_reg[0] <= T_ZERO;
            turn_back_reg[1] <= T_ZERO;
            check_reg[0]     <= T_ZERO;
            check_reg[1]     <= T_ZERO;
            res_valid_reg    <= 1'b0;
        end
        else if (req_accept)
        begin
            open_next_commit: begin
                open_reg         <= open_next;
                lock_reg         <= lock_next;
                usable_reg       <= usable_next;
                fault_reg        <= fault_next;
                testing_reg      <= testing_next;
                drive_reg        <= drive_next;
                detect_reg       <= detect_next;
                delay_reg        <= delay_next;
                turn_back_reg[0] <= turn_back_next[0];
                turn_back_reg[1] <= turn_back_next[1];
                check_reg[0]     <= check_next[0];
                check_reg[1]     <= check_next[1];
                res_valid_reg    <= 1'b1;
            end
        end
        else if (result.ready)
        begin
            // Drop the result once taken
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept) res_reg <= res_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.left_drive     = res_reg.left_drive;
    assign result.right_drive    = res_reg.right_drive;
    assign result.valve_is_open  = res_reg.valve_is_open;
    assign result.locked         = res_reg.locked;
    assign result.valve_usable   = res_reg.valve_usable;
    assign result.left_fault     = res_reg.left_fault;
    assign result.right_fault    = res_reg.right_fault;
    assign result.left_testing   = res_reg.left_testing;
    assign result.right_testing  = res_reg.right_testing;
    assign result.command_status = res_reg.command_status;
    assign result.master_report  = res_reg.master_report;
    assign result.check_report   = res_reg.check_report;

endmodule
`default_nettype wire

### design/dvast_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual valve actuator self-test checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
module dvast_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       req_valid,
    input wire       req_ready,
    input wire       res_valid,
    input wire       res_ready,
    input wire       valve_is_open,
    input wire       left_fault,
    input wire       left_testing,
    input wire [1:0] check_report,
    input wire [1:0] master_report
);

    // Stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(check_report) &&
                                    $stable(master_report))
        else $error("result changed while stalled");

    // No new request while the result register is blocked
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !req_ready)
        else $error("request accepted over a stalled result");

    // Each accepted request shows a result next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> res_valid)
        else $error("accepted request produced no result");

    // A left pass ends the left test without a fault
    a_left_pass: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && check_report[0] |-> !left_testing && !left_fault)
        else $error("left pass reported with test or fault active");

    // Reported open implies valve open
    a_open_rpt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && master_report == dvast_pkg::RPT_OPENED |-> valve_is_open)
        else $error("open reported with valve closed");

endmodule

bind dual_valve_actuator_self_test dvast_checker u_dvast_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .valve_is_open (result.valve_is_open),
    .left_fault    (result.left_fault),
    .left_testing  (result.left_testing),
    .check_report  (result.check_report),
    .master_report (result.master_report)
);
`default_nettype wire

### dv/dvast_result_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual valve actuator self-test result check
// Watches the configuration, request and result channels, keeps its own copy
// of the valve state and countdown timers, and compares every result
// transaction field by field against the predicted one.
// ----------------------------------------------------------------------------
module dvast_result_check (
    input  wire   clk,
    input  wire   rst_n,
    dvast_cfg_if  cfg,
    dvast_req_if  request,
    dvast_res_if  result,
    output int    fail_count,
    output int    outstanding
);
    import dvast_pkg::*;

    // Countdown timer slots, in firing order
    localparam int TM_DETECT = 0;
    localparam int TM_DELAY  = 1;
    localparam int TM_TB_L   = 2;
    localparam int TM_TB_R   = 3;
    localparam int TM_CK_L   = 4;
    localparam int TM_CK_R   = 5;
    localparam int TM_COUNT  = 6;

    logic [CFG_W-1:0] period_q [5];
    logic             open_q;
    logic             lock_q;
    logic             usable_q;
    logic [1:0]       fault_q;
    logic [1:0]       testing_q;
    logic [1:0]       drive_q;
    logic [CFG_W-1:0] remain_q [TM_COUNT];
    logic [TM_COUNT-1:0] expired;

    // Per-transaction inputs and reports
    logic [1:0]       switch_now;
    logic             mode_now;
    report_t          master_now;
    logic [1:0]       passed_now;

    result_t          expected_q [$];
    int               mismatches;

    assign fail_count = mismatches;

    function automatic void arm_timer(int id);
        logic [CFG_W-1:0] p;
        case (id)
            TM_DETECT: p = period_q[REG_DETECT_DELAY];
            TM_DELAY:  p = period_q[REG_DELAY_CLOSE];
            TM_TB_L,
            TM_TB_R:   p = period_q[REG_TURN_BACK];
            TM_CK_L:   p = period_q[REG_LEFT_CHECK];
            default:   p = period_q[REG_RIGHT_CHECK];
        endcase
        if (p == '0)
            p = 1;
        remain_q[id] = p;
        expired[id]  = 1'b0;
    endfunction

    function automatic void halt_timer(int id);
        remain_q[id] = '0;
        expired[id]  = 1'b0;
    endfunction

    function automatic void drive_both(logic v);
        open_q  = v;
        drive_q = {v, v};
    endfunction

    function automatic void halt_self_test();
        halt_timer(TM_TB_L);
        halt_timer(TM_TB_R);
        halt_timer(TM_CK_L);
        halt_timer(TM_CK_R);
        halt_timer(TM_DELAY);
    endfunction

    function automatic status_t open_valve();
        if (lock_q || !usable_q)
            return ST_REFUSED;
        drive_both(1'b1);
        halt_self_test();
        arm_timer(TM_DETECT);
        return ST_DONE;
    endfunction

    // Motors are released even when the close is refused
    function automatic status_t close_valve();
        drive_both(1'b0);
        if (!usable_q)
            return ST_REFUSED;
        halt_self_test();
        halt_timer(TM_DETECT);
        return ST_DONE;
    endfunction

    function automatic void begin_self_test();
        int s;
        if (!open_q)
            return;
        for (s = 0; s < 2; s++) begin
            if (switch_now[s] == 1'b0) begin
                halt_timer(TM_TB_L + s);
                halt_timer(TM_CK_L + s);
                fault_q[s]   = 1'b0;
                testing_q[s] = 1'b1;
                drive_q[s]   = 1'b0;
                arm_timer(TM_TB_L + s);
            end
        end
    endfunction

    function automatic void timer_expired(int id);
        int s;
        if (id == TM_DETECT) begin
            begin_self_test();
        end else if (id == TM_DELAY) begin
            if (mode_now) begin
                lock_q = 1'b1;
                void'(close_valve());
                master_now = RPT_CLOSED;
            end
        end else if (id == TM_TB_L || id == TM_TB_R) begin
            s = id - TM_TB_L;
            if (switch_now[s]) begin
                drive_q[s] = 1'b1;
                arm_timer(TM_CK_L + s);
            end else begin
                usable_q     = 1'b0;
                fault_q[s]   = 1'b1;
                testing_q[s] = 1'b0;
            end
        end else begin
            s = id - TM_CK_L;
            testing_q[s] = 1'b0;
            if (!switch_now[s]) begin
                if (!fault_q[1-s])
                    usable_q = 1'b1;
                fault_q[s]    = 1'b0;
                passed_now[s] = 1'b1;
            end else begin
                usable_q   = 1'b0;
                fault_q[s] = 1'b1;
            end
        end
    endfunction

    // Count every running timer first, then fire the expired ones in order
    function automatic void count_tick();
        int id;
        for (id = 0; id < TM_COUNT; id++) begin
            expired[id] = 1'b0;
            if (remain_q[id] != '0) begin
                remain_q[id] = remain_q[id] - 1'b1;
                if (remain_q[id] == '0)
                    expired[id] = 1'b1;
            end
        end
        for (id = 0; id < TM_COUNT; id++) begin
            if (expired[id]) begin
                expired[id] = 1'b0;
                timer_expired(id);
            end
        end
    endfunction

    function automatic result_t predict_result(command_t cmd, logic lvl, logic sd,
                                               logic lsw, logic rsw, logic md);
        status_t st;
        result_t r;
        st         = ST_DONE;
        switch_now = {rsw, lsw};
        mode_now   = md;
        master_now = RPT_NONE;
        passed_now = 2'b00;
        case (cmd)
            CMD_TICK:   count_tick();
            CMD_OPEN:   st = open_valve();
            CMD_CLOSE:  st = close_valve();
            CMD_LOCK:   lock_q = 1'b1;
            CMD_UNLOCK: lock_q = 1'b0;
            CMD_DRY_CONTACT: begin
                if (!md) begin
                    st = ST_IGNORED;
                end else if (lvl) begin
                    st = close_valve();
                    if (st == ST_DONE)
                        master_now = RPT_CLOSED;
                end else begin
                    st = open_valve();
                    if (st == ST_DONE)
                        master_now = RPT_OPENED;
                end
            end
            CMD_DELAY_ARM: begin
                if (lvl)
                    arm_timer(TM_DELAY);
                else
                    halt_timer(TM_DELAY);
            end
            default: drive_q[sd] = lvl;
        endcase
        r.left_drive     = drive_q[0];
        r.right_drive    = drive_q[1];
        r.valve_is_open  = open_q;
        r.locked         = lock_q;
        r.valve_usable   = usable_q;
        r.left_fault     = fault_q[0];
        r.right_fault    = fault_q[1];
        r.left_testing   = testing_q[0];
        r.right_testing  = testing_q[1];
        r.command_status = st;
        r.master_report  = master_now;
        r.check_report   = passed_now;
        return r;
    endfunction

    function automatic void check_field(string name, logic [1:0] want_v, logic [1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        int      i;
        if (!rst_n) begin
            period_q[REG_DETECT_DELAY] = DETECT_DELAY_RST;
            period_q[REG_DELAY_CLOSE]  = DELAY_CLOSE_RST;
            period_q[REG_TURN_BACK]    = TURN_BACK_RST;
            period_q[REG_LEFT_CHECK]   = LEFT_CHECK_RST;
            period_q[REG_RIGHT_CHECK]  = RIGHT_CHECK_RST;
            open_q    = 1'b0;
            lock_q    = 1'b0;
            usable_q  = 1'b1;
            fault_q   = 2'b00;
            testing_q = 2'b00;
            drive_q   = 2'b00;
            for (i = 0; i < TM_COUNT; i++)
                remain_q[i] = '0;
            expired    = '0;
            mismatches = 0;
            expected_q.delete();
            outstanding <= 0;
        end else begin
            // Retire the result first: it always belongs to an earlier request
            if (result.valid && result.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result transaction with no request pending", $time);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("left_drive", want.left_drive, result.left_drive);
                    check_field("right_drive", want.right_drive, result.right_drive);
                    check_field("valve_is_open", want.valve_is_open, result.valve_is_open);
                    check_field("locked", want.locked, result.locked);
                    check_field("valve_usable", want.valve_usable, result.valve_usable);
                    check_field("left_fault", want.left_fault, result.left_fault);
                    check_field("right_fault", want.right_fault, result.right_fault);
                    check_field("left_testing", want.left_testing, result.left_testing);
                    check_field("right_testing", want.right_testing, result.right_testing);
                    check_field("command_status", want.command_status,
                                result.command_status);
                    check_field("master_report", want.master_report, result.master_report);
                    check_field("check_report", want.check_report, result.check_report);
                end
            end
            if (cfg.valid && cfg.ready && cfg.index <= REG_RIGHT_CHECK)
                period_q[cfg.index] = cfg.data;
            if (request.valid && request.ready)
                expected_q.push_back(predict_result(request.command, request.level,
                    request.side, request.left_open_switch, request.right_open_switch,
                    request.mode_allows));
            outstanding <= expected_q.size();
        end
    end

endmodule
`default_nettype wire

### dv/tb_dual_valve_actuator_self_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual valve actuator self-test testbench
// Drives commands and millisecond ticks through the request channel, with
// directed checks of each command and scripted self-test rounds (open, detect,
// release, redrive) under several timer settings, then random traffic after a
// forced fault. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module tb_dual_valve_actuator_self_test;
    import dvast_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [CFG_W-1:0] PERIOD_MAX = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int outstanding;
    int accepted_cnt = 0;
    int sent_items   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    dvast_cfg_if cfg_bus ();
    dvast_req_if req_bus ();
    dvast_res_if res_bus ();

    dual_valve_actuator_self_test dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .request (req_bus),
        .result  (res_bus)
    );

    dvast_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .request     (req_bus),
        .result      (res_bus),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
        if (req_bus.valid && req_bus.ready)
            accepted_cnt <= accepted_cnt + 1;

    // Idle mix moves with progress: sender-light, then receiver-light, then none
    function automatic int sender_idle_pct();
        if (accepted_cnt < 320)
            return 23;
        else if (accepted_cnt < 640)
            return 71;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_cnt < 320)
            return 71;
        else if (accepted_cnt < 640)
            return 23;
        return 0;
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // Result side; one long hold-off lets the block back up into its input
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                res_bus.ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && accepted_cnt >= 90) begin
                hold_done = 1'b1;
                hold_left = 80;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    task automatic put_request(command_t cmd, logic lvl, logic sd, logic lsw, logic rsw,
                               logic md);
        while ($urandom_range(99) < sender_idle_pct()) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid             <= 1'b1;
        req_bus.command           <= cmd;
        req_bus.level             <= lvl;
        req_bus.side              <= sd;
        req_bus.left_open_switch  <= lsw;
        req_bus.right_open_switch <= rsw;
        req_bus.mode_allows       <= md;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic wait_results_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic program_timers(logic [CFG_W-1:0] detect, logic [CFG_W-1:0] delay_close,
                                  logic [CFG_W-1:0] turn_back, logic [CFG_W-1:0] left_check,
                                  logic [CFG_W-1:0] right_check);
        logic [CFG_IDX_W-1:0] idx  [5];
        logic [CFG_W-1:0]     vals [5];
        int r;
        idx  = '{REG_DETECT_DELAY, REG_DELAY_CLOSE, REG_TURN_BACK, REG_LEFT_CHECK,
                 REG_RIGHT_CHECK};
        vals = '{detect, delay_close, turn_back, left_check, right_check};
        for (r = 0; r < 5; r++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[r];
            cfg_bus.data  <= vals[r];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // Lock, unlock, drive, delay-arm or ignored dry-contact commands, unless any is set
    task automatic put_filler(bit any);
        command_t cmd;
        logic     md;
        if (any) begin
            cmd = command_t'($urandom_range(7));
        end else begin
            case ($urandom_range(4))
                0:       cmd = CMD_LOCK;
                1:       cmd = CMD_UNLOCK;
                2:       cmd = CMD_DRIVE;
                3:       cmd = CMD_DELAY_ARM;
                default: cmd = CMD_DRY_CONTACT;
            endcase
        end
        md = (cmd == CMD_DRY_CONTACT && !any) ? 1'b0 : coin();
        put_request(cmd, coin(), coin(), coin(), coin(), md);
    endtask

    // One open followed by ticks whose switch levels follow a healthy valve;
    // a noisy round flips one switch reading and may slip in any command.
    task automatic run_self_test_round(int d, int tb, int cl, int cr, int noise_pct);
        logic [1:0] joins;
        logic [1:0] sw;
        bit         noisy;
        int         span;
        int         k;
        int         wrong_tick;
        int         s;
        joins = ($urandom_range(9) < 6) ? 2'b11 : 2'($urandom_range(3));
        span  = d + tb + ((cl > cr) ? cl : cr) + $urandom_range(3);
        noisy = ($urandom_range(99) < noise_pct);
        wrong_tick = noisy ? $urandom_range(span, 1) : 0;
        if ($urandom_range(9) < 8)
            put_request(CMD_UNLOCK, coin(), coin(), coin(), coin(), coin());
        if (coin())
            put_request(CMD_OPEN, coin(), coin(), coin(), coin(), coin());
        else
            put_request(CMD_DRY_CONTACT, 1'b0, coin(), coin(), coin(), 1'b1);
        for (k = 1; k <= span; k++) begin
            if ($urandom_range(3) == 0)
                put_filler(noisy && coin());
            for (s = 0; s < 2; s++) begin
                if (k <= d)
                    sw[s] = !joins[s];
                else if (k <= d + tb)
                    sw[s] = 1'b1;
                else
                    sw[s] = 1'b0;
            end
            if (k == wrong_tick)
                sw[$urandom_range(1)] ^= 1'b1;
            put_request(CMD_TICK, coin(), coin(), sw[0], sw[1], coin());
        end
        if (coin())
            put_request(CMD_CLOSE, coin(), coin(), coin(), coin(), coin());
    endtask

    initial begin
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= REG_DETECT_DELAY;
        cfg_bus.data              <= '0;
        req_bus.valid             <= 1'b0;
        req_bus.command           <= CMD_TICK;
        req_bus.level             <= 1'b0;
        req_bus.side              <= 1'b0;
        req_bus.left_open_switch  <= 1'b0;
        req_bus.right_open_switch <= 1'b0;
        req_bus.mode_allows       <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every command under the reset timer settings
        put_request(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        put_request(CMD_OPEN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_LOCK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_OPEN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);          // refused by lock
        put_request(CMD_DRY_CONTACT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);   // ignored by mode
        put_request(CMD_DRY_CONTACT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        put_request(CMD_UNLOCK, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
        put_request(CMD_DRY_CONTACT, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
        put_request(CMD_DRIVE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        put_request(CMD_DRIVE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_DELAY_ARM, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        put_request(CMD_DELAY_ARM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        put_request(CMD_CLOSE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        wait_results_drained();

        // Short periods: a full passing self-test, delay-close with and without mode
        program_timers(24'd2, 24'd1, 24'd1, 24'd2, 24'd1);
        put_request(CMD_OPEN, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);          // self-test starts
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);          // redrive
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);          // right passes
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);          // left passes
        put_request(CMD_DELAY_ARM, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);          // lock and close
        put_request(CMD_DELAY_ARM, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);          // mode blocks it
        put_request(CMD_UNLOCK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_OPEN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_CLOSE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);         // testing flags stay
        wait_results_drained();

        program_timers(24'd3, 24'd40, 24'd2, 24'd3, 24'd5);
        while (sent_items < 360)
            run_self_test_round(3, 2, 3, 5, 0);
        wait_results_drained();

        // Shortest periods: every timer expires on the first tick after it starts
        program_timers(24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
        while (sent_items < 610)
            run_self_test_round(1, 1, 1, 1, 0);
        wait_results_drained();

        // Zero left check counts as one; delay-close never expires
        program_timers(24'd2, PERIOD_MAX, 24'd3, 24'd0, 24'd2);
        while (sent_items < 810)
            run_self_test_round(2, 3, 1, 2, 20);
        wait_results_drained();

        // Force a turn-back failure, then random traffic on an unusable valve
        program_timers(24'd1, 24'd5, 24'd1, PERIOD_MAX, PERIOD_MAX);
        put_request(CMD_UNLOCK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_OPEN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        put_request(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        while (sent_items < 960) begin
            if ($urandom_range(2) == 0)
                put_request(CMD_TICK, coin(), coin(), coin(), coin(), coin());
            else
                put_filler(1'b1);
        end
        wait_results_drained();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

### dual_valve_actuator_self_test.f
design/dvast_pkg.sv
design/dvast_if.sv
design/dual_valve_actuator_self_test.sv
design/dvast_checker.sv
dv/dvast_result_check.sv
dv/tb_dual_valve_actuator_self_test.sv
